// ===== sv/agwh_pkg.sv =====
// agwh_pkg: shared types and constants for the amplitude gate with hold
// holds field widths, register index codes and register reset values
// no dependencies
`default_nettype none

package agwh_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CNT_W    = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_W-1:0]           cfg_data_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  typedef enum logic [0:0] {
    REG_LEVEL_THRESHOLD = 1'b0,
    REG_HOLD_COUNT      = 1'b1
  } reg_idx_t;

  localparam cfg_data_t LEVEL_THRESHOLD_RST = 16'd1024;
  localparam cfg_data_t HOLD_COUNT_RST      = 16'd1000;

endpackage

`default_nettype wire

// ===== sv/amplitude_gate_with_hold.sv =====
// amplitude_gate_with_hold: noise gate with hold time, one sample per word
// registered input stage, gate decision and result register
// depends on agwh_pkg
//
// usage:
//   input channel in_valid/in_stall carries one signed 16-bit sample a word.
//   result channel out_valid/out_stall carries the same sample with keep,
//   segment_start and segment_end flags, exactly one result per sample.
//   a word moves on a rising edge with valid high and stall low.
//   a sample passes the input register, then the result register; throughput
//   is one sample per cycle while out_stall stays low, set by the input register
//   feeding the result register through a single compare and counter update.
//   when the receiver stalls, the result register holds its word and the
//   input register absorbs one more sample before in_stall rises.
//   cfg_we/cfg_index/cfg_wdata write level_threshold (index 0) and
//   hold_count (index 1); write only while no samples are in flight.
//   reset (rst_n low, synchronous) empties both stages, returns the gate to
//   idle with a zero quiet count and loads threshold 1024 and hold 1000.
`default_nettype none

module amplitude_gate_with_hold (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire agwh_pkg::sample_t in_sample_in,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      agwh_pkg::sample_t out_sample_out,
  output      logic              out_keep,
  output      logic              out_segment_start,
  output      logic              out_segment_end,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire agwh_pkg::cfg_data_t cfg_wdata
);
  import agwh_pkg::*;

  localparam int unsigned EXT_W = SAMPLE_W + 2;

  cfg_data_t level_threshold_r;
  cfg_data_t hold_count_r;

  logic      s1_valid_r;
  sample_t   s1_sample_r;

  logic      recording_r, recording_nxt;
  cnt_t      quiet_run_r, quiet_run_nxt;

  logic      out_valid_r;
  sample_t   out_sample_r;
  logic      out_keep_r, out_keep_nxt;
  logic      out_start_r, out_start_nxt;
  logic      out_end_r, out_end_nxt;

  logic      out_ready;
  logic      s1_adv;
  logic      loud;

  logic signed [EXT_W-1:0] s_ext;
  logic signed [EXT_W-1:0] t_ext;
  logic signed [EXT_W-1:0] t_neg;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_threshold_r <= LEVEL_THRESHOLD_RST;
      hold_count_r      <= HOLD_COUNT_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LEVEL_THRESHOLD: level_threshold_r <= cfg_wdata;
        REG_HOLD_COUNT:      hold_count_r      <= cfg_wdata;
        default:             ;
      endcase
    end
  end

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample_r <= in_sample_in;
    end
  end

  // magnitude test in a widened signed domain so threshold up to 65535 works
  assign s_ext = EXT_W'(s1_sample_r);
  assign t_ext = $signed({2'b00, level_threshold_r});
  assign t_neg = -t_ext;
  assign loud  = (s_ext >= t_ext) || (s_ext <= t_neg);

  always_comb begin
    recording_nxt = recording_r;
    quiet_run_nxt = quiet_run_r;
    out_keep_nxt  = 1'b0;
    out_start_nxt = 1'b0;
    out_end_nxt   = 1'b0;
    if (recording_r) begin
      if (loud) begin
        quiet_run_nxt = '0;
        out_keep_nxt  = 1'b1;
      end else if (quiet_run_r < hold_count_r) begin
        quiet_run_nxt = quiet_run_r + CNT_W'(1);
        out_keep_nxt  = 1'b1;
      end else begin
        recording_nxt = 1'b0;
        quiet_run_nxt = '0;
        out_end_nxt   = 1'b1;
      end
    end else if (loud) begin
      recording_nxt = 1'b1;
      quiet_run_nxt = '0;
      out_keep_nxt  = 1'b1;
      out_start_nxt = 1'b1;
    end
  end

  // gate state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recording_r <= 1'b0;
      quiet_run_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv) begin
        recording_r <= recording_nxt;
        quiet_run_r <= quiet_run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sample_r <= s1_sample_r;
      out_keep_r   <= out_keep_nxt;
      out_start_r  <= out_start_nxt;
      out_end_r    <= out_end_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_out    = out_sample_r;
  assign out_keep          = out_keep_r;
  assign out_segment_start = out_start_r;
  assign out_segment_end   = out_end_r;

endmodule

`default_nettype wire

// ===== sv/agwh_checker.sv =====
// agwh_checker: port-level checks for amplitude_gate_with_hold
// bound to the top level below
// depends on agwh_pkg
`default_nettype none

module agwh_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire agwh_pkg::sample_t out_sample_out,
  input wire logic              out_keep,
  input wire logic              out_segment_start,
  input wire logic              out_segment_end
);
  import agwh_pkg::*;

  // pipeline is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // a dropped closing sample is never also kept
  a_end_not_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_keep && out_segment_end))
    else $error("segment_end with keep set");

  // an opening sample is kept and does not close anything
  a_start_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_segment_start) |-> (out_keep && !out_segment_end))
    else $error("segment_start without keep or with segment_end");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_sample_out)))
    else $error("stalled result changed");

  // input only stalls behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while result side can move");

endmodule

bind amplitude_gate_with_hold agwh_checker u_agwh_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_sample_out    (out_sample_out),
  .out_keep          (out_keep),
  .out_segment_start (out_segment_start),
  .out_segment_end   (out_segment_end)
);

`default_nettype wire

// ===== dv/tb_amplitude_gate_with_hold.sv =====
// tb_amplitude_gate_with_hold: self-checking testbench for the amplitude gate with hold
// directed table then random segment-shaped stimulus, checked against a gate predictor
// depends on agwh_pkg and amplitude_gate_with_hold
module tb_amplitude_gate_with_hold;
  timeunit 1ns;
  timeprecision 1ps;

  import agwh_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RAND_BLOCK_WORDS = 70;

  // expected flags as {keep, segment_start, segment_end}
  localparam logic [2:0] F_NONE  = 3'b000;
  localparam logic [2:0] F_KEEP  = 3'b100;
  localparam logic [2:0] F_OPEN  = 3'b110;
  localparam logic [2:0] F_CLOSE = 3'b001;

  typedef struct packed {
    sample_t smp;
    logic    keep;
    logic    seg_start;
    logic    seg_end;
  } gate_word_t;

  typedef struct {
    bit        is_cfg;
    reg_idx_t  idx;
    cfg_data_t val;
    sample_t   smp;
    bit        typed;
    logic [2:0] flags;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  sample_t   in_sample_in = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  sample_t   out_sample_out;
  logic      out_keep;
  logic      out_segment_start;
  logic      out_segment_end;
  logic      cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  cfg_data_t cfg_wdata = '0;

  // predictor state and register copies
  bit        gate_open = 1'b0;
  cnt_t      quiet_cnt = '0;
  cfg_data_t thr_q = LEVEL_THRESHOLD_RST;
  cfg_data_t hold_q = HOLD_COUNT_RST;

  gate_word_t expected_words[$];
  int send_idle_pct = 30;
  int recv_stall_pct = 48;
  int n_sent = 0;
  int n_checked = 0;
  int n_opened = 0;
  int n_closed = 0;
  int n_cfg = 0;
  int n_bad = 0;
  int cycle_cnt = 0;

  amplitude_gate_with_hold uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_in      (in_sample_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample_out    (out_sample_out),
    .out_keep          (out_keep),
    .out_segment_start (out_segment_start),
    .out_segment_end   (out_segment_end),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic gate_word_t gate_predict(input sample_t s);
    gate_word_t w;
    int t;
    bit loud;
    t = int'(thr_q);
    loud = (int'(s) >= t) || (int'(s) <= -t);
    w = '{smp: s, keep: 1'b0, seg_start: 1'b0, seg_end: 1'b0};
    if (gate_open) begin
      if (loud) begin
        quiet_cnt = '0;
        w.keep = 1'b1;
      end else if (quiet_cnt < hold_q) begin
        quiet_cnt = quiet_cnt + 1'b1;
        w.keep = 1'b1;
      end else begin
        gate_open = 1'b0;
        quiet_cnt = '0;
        w.seg_end = 1'b1;
      end
    end else if (loud) begin
      gate_open = 1'b1;
      quiet_cnt = '0;
      w.keep = 1'b1;
      w.seg_start = 1'b1;
    end
    return w;
  endfunction

  // random sample that is loud or quiet under the current threshold,
  // leaning on the threshold boundary now and then
  function automatic sample_t make_sample(input bit loud);
    int t;
    int m;
    t = int'(thr_q);
    if (loud && t <= 32768) begin
      if (t == 32768 || $urandom_range(15) == 0) return sample_t'(-32768);
      m = ($urandom_range(7) == 0) ? t : int'($urandom_range(32767, t));
      return ($urandom_range(1) == 1) ? sample_t'(-m) : sample_t'(m);
    end
    if (!loud && t > 0) begin
      if (t > 32768) m = $urandom_range(32767, 0);
      else if ($urandom_range(7) == 0) m = t - 1;
      else m = $urandom_range(t - 1, 0);
      return ($urandom_range(1) == 1) ? sample_t'(-m) : sample_t'(m);
    end
    return sample_t'($urandom_range(65535, 0));
  endfunction

  function automatic stim_row_t rt(input sample_t s, input logic [2:0] flags);
    return '{is_cfg: 1'b0, idx: REG_LEVEL_THRESHOLD, val: '0, smp: s, typed: 1'b1,
             flags: flags};
  endfunction

  function automatic stim_row_t rp(input sample_t s);
    return '{is_cfg: 1'b0, idx: REG_LEVEL_THRESHOLD, val: '0, smp: s, typed: 1'b0,
             flags: F_NONE};
  endfunction

  function automatic stim_row_t rw(input reg_idx_t idx, input cfg_data_t v);
    return '{is_cfg: 1'b1, idx: idx, val: v, smp: '0, typed: 1'b0, flags: F_NONE};
  endfunction

  task automatic push_sample(input sample_t s, input bit typed = 1'b0,
                             input logic [2:0] flags = F_NONE);
    gate_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (in_stall);
    w = gate_predict(s);
    if (typed) w = '{smp: s, keep: flags[2], seg_start: flags[1], seg_end: flags[0]};
    expected_words = {expected_words, w};
    n_sent++;
  endtask

  // hold the input until every outstanding word has come back
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input cfg_data_t v);
    wait_all_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LEVEL_THRESHOLD) thr_q = v;
    else hold_q = v;
    n_cfg++;
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    gate_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_checked++;
      if (out_segment_start) n_opened++;
      if (out_segment_end) n_closed++;
      if (expected_words.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("[%0t] unexpected word: sample %0d keep %b start %b end %b", $time,
                   out_sample_out, out_keep, out_segment_start, out_segment_end);
      end else begin
        want = expected_words.pop_front();
        if (out_sample_out !== want.smp || out_keep !== want.keep ||
            out_segment_start !== want.seg_start || out_segment_end !== want.seg_end) begin
          n_bad++;
          if (n_bad <= 10)
            $display("[%0t] mismatch: expected %0d/%b%b%b got %0d/%b%b%b", $time,
                     want.smp, want.keep, want.seg_start, want.seg_end, out_sample_out,
                     out_keep, out_segment_start, out_segment_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt,
               expected_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    stim_row_t plan[$];
    cfg_data_t thr;
    cfg_data_t hold;
    int blk_words;
    int n_loud;
    int qlen;

    plan = '{
      // power-on settings: threshold 1024, hold 1000
      rt(16'sd0, F_NONE), rt(16'sd1023, F_NONE), rt(-16'sd1023, F_NONE),
      rt(16'sd1024, F_OPEN), rt(16'sd32767, F_KEEP), rt(-16'sd32768, F_KEEP),
      rt(-16'sd1024, F_KEEP), rt(16'sd5, F_KEEP),
      // zero hold: first quiet word closes the segment
      rw(REG_HOLD_COUNT, 16'd0),
      rt(16'sd100, F_CLOSE), rt(16'sd2000, F_OPEN), rt(16'sd0, F_CLOSE),
      // zero threshold: everything is loud
      rw(REG_LEVEL_THRESHOLD, 16'd0),
      rt(16'sd0, F_OPEN), rt(-16'sd1, F_KEEP),
      // threshold 32768: only the most negative sample is loud
      rw(REG_LEVEL_THRESHOLD, 16'h8000),
      rt(16'sd32767, F_CLOSE), rt(-16'sd32768, F_OPEN), rt(-16'sd32767, F_CLOSE),
      // thresholds past 32768: nothing is loud
      rw(REG_LEVEL_THRESHOLD, 16'd40000),
      rt(-16'sd32768, F_NONE), rt(16'sd32767, F_NONE),
      rw(REG_LEVEL_THRESHOLD, 16'hFFFF),
      rt(-16'sd32768, F_NONE),
      rw(REG_LEVEL_THRESHOLD, 16'd1), rw(REG_HOLD_COUNT, 16'hFFFF),
      rt(16'sd1, F_OPEN), rt(16'sd0, F_KEEP), rt(16'sd0, F_KEEP), rp(-16'sd1),
      rw(REG_LEVEL_THRESHOLD, 16'd32767), rw(REG_HOLD_COUNT, 16'd2),
      rp(-16'sd21846), rp(16'sd21845)
    };

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].val);
      else push_sample(plan[i].smp, plan[i].typed, plan[i].flags);
    end

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 48 : 0;
      recv_stall_pct = (mode == 0) ? 48 : (mode == 1) ? 30 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        case ($urandom_range(7))
          0: thr = '0;
          1: thr = 16'h8000;
          2: thr = cfg_data_t'($urandom_range(65535, 32769));
          3: thr = cfg_data_t'($urandom_range(32767, 4000));
          default: thr = cfg_data_t'($urandom_range(3000, 1));
        endcase
        case ($urandom_range(5))
          0: hold = '0;
          1: hold = 16'hFFFF;
          default: hold = cfg_data_t'($urandom_range(10, 1));
        endcase
        write_reg(REG_LEVEL_THRESHOLD, thr);
        write_reg(REG_HOLD_COUNT, hold);
        blk_words = 0;
        while (blk_words < RAND_BLOCK_WORDS) begin
          if ($urandom_range(9) == 0) begin
            push_sample(sample_t'($urandom_range(65535, 0)));
            blk_words++;
          end else begin
            // a loud burst followed by a quiet tail around the hold length
            n_loud = $urandom_range(4, 1);
            qlen = (hold_q <= 40) ? int'($urandom_range(int'(hold_q) + 2, 0))
                                  : int'($urandom_range(40, 0));
            repeat (n_loud) push_sample(make_sample(1'b1));
            repeat (qlen) push_sample(make_sample(1'b0));
            blk_words += n_loud + qlen;
          end
        end
      end
    end

    wait_all_results();
    repeat (10) @(posedge clk);

    $display("sent %0d samples across %0d register writes and three stall mixes",
             n_sent, n_cfg);
    $display("checked %0d words: %0d segments opened, %0d closed, %0d mismatches",
             n_checked, n_opened, n_closed, n_bad);
    if (n_bad == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
